// File: hdl/apsd_pkg.sv
`default_nettype none

package apsd_pkg;

  localparam int HISTORY_DEPTH = 4;
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = 16 + $clog2(HISTORY_DEPTH + 1);

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [2:0] CFG_MIN_PEAK_GAP = 3'd0;
  localparam logic [2:0] CFG_MIN_UPDATE_SWING = 3'd1;
  localparam logic [2:0] CFG_PEAK_LOW = 3'd2;
  localparam logic [2:0] CFG_PEAK_HIGH = 3'd3;
  localparam logic [2:0] CFG_MIN_RISE_COUNT = 3'd4;

  localparam logic [7:0] RST_MIN_PEAK_GAP = 8'd25;
  localparam logic [15:0] RST_MIN_UPDATE_SWING = 16'd2172;
  localparam logic [15:0] RST_PEAK_LOW = 16'd18010;
  localparam logic [15:0] RST_PEAK_HIGH = 16'd32746;
  localparam logic [3:0] RST_MIN_RISE_COUNT = 4'd2;

  localparam logic [15:0] THR_43 = 16'd7184;
  localparam logic [15:0] THR_33 = 16'd5513;
  localparam logic [15:0] THR_23 = 16'd3843;
  localparam logic [15:0] THR_20 = 16'd3341;
  localparam logic [15:0] THR_13 = 16'd2172;

  localparam logic [SUM_W-1:0] SUM_B8 = SUM_W'(13366 * HISTORY_DEPTH);
  localparam logic [SUM_W-1:0] SUM_B7 = SUM_W'(11695 * HISTORY_DEPTH);
  localparam logic [SUM_W-1:0] SUM_B4 = SUM_W'(6683 * HISTORY_DEPTH);
  localparam logic [SUM_W-1:0] SUM_B3 = SUM_W'(5012 * HISTORY_DEPTH);

  typedef struct packed {
    logic req_type;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic step_found;
    logic [15:0] magnitude;
    logic [15:0] threshold_now;
  } result_t;

  typedef struct packed {
    logic [7:0] min_peak_gap;
    logic [15:0] min_update_swing;
    logic [15:0] peak_low;
    logic [15:0] peak_high;
    logic [3:0] min_rise_count;
  } cfg_t;

  typedef struct packed {
    logic commit;
    logic is_tick;
    logic [15:0] mag;
  } commit_t;

  // Comparing the history sum against scaled bounds equals grading the floor mean.
  function automatic logic [15:0] grade(input logic [SUM_W-1:0] sum);
    logic [15:0] thr;
    if (sum >= SUM_B8) begin
      thr = THR_43;
    end else if (sum >= SUM_B7) begin
      thr = THR_33;
    end else if (sum >= SUM_B4) begin
      thr = THR_23;
    end else if (sum >= SUM_B3) begin
      thr = THR_20;
    end else begin
      thr = THR_13;
    end
    return thr;
  endfunction

endpackage

`default_nettype wire

// File: hdl/apsd_sqsum.sv
`default_nettype none

module apsd_sqsum (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic signed [15:0] z,
  output logic [31:0]             sum,
  output logic                    done
);

  logic signed [15:0] ax0;
  logic signed [15:0] ax1;
  logic signed [15:0] ax2;
  logic [1:0] cnt;
  logic busy;
  logic [30:0] prod;
  logic signed [31:0] sq_full;

  assign sq_full = ax0 * ax0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 2'd3);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == 2'd3)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ax0 <= x;
      ax1 <= y;
      ax2 <= z;
      cnt <= 2'd0;
      sum <= 32'd0;
    end else if (busy) begin
      prod <= sq_full[30:0];
      ax0 <= ax1;
      ax1 <= ax2;
      cnt <= cnt + 2'd1;
      if (cnt != 2'd0) begin
        sum <= sum + {1'b0, prod};
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/apsd_isqrt.sv
`default_nettype none

module apsd_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] radicand,
  output logic [15:0]      root,
  output logic             done
);

  logic [31:0] rad;
  logic [16:0] rem;
  logic [3:0] cnt;
  logic busy;
  logic [18:0] rem_sh;
  logic [18:0] trial;
  logic [18:0] diff;

  // Two radicand bits enter the partial remainder per cycle; one root bit leaves.
  assign rem_sh = {rem, rad[31:30]};
  assign trial = {1'b0, root, 2'b01};
  assign diff = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 4'd15);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == 4'd15)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= 17'd0;
      root <= 16'd0;
      cnt <= 4'd0;
    end else if (busy) begin
      rad <= {rad[29:0], 2'b00};
      cnt <= cnt + 4'd1;
      if (rem_sh >= trial) begin
        rem <= diff[16:0];
        root <= {root[14:0], 1'b1};
      end else begin
        rem <= rem_sh[16:0];
        root <= {root[14:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/apsd_track.sv
`default_nettype none

module apsd_track (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire apsd_pkg::cfg_t  cfg,
  input  wire apsd_pkg::commit_t cmt,
  output apsd_pkg::result_t    res
);

  logic [31:0] tick_count;
  logic [15:0] prev_magnitude;
  logic rising_now;
  logic [3:0] rise_run;
  logic [15:0] valley_value;
  logic [31:0] last_peak_time;
  logic [15:0] step_threshold;
  logic [apsd_pkg::FILL_W-1:0] history_fill;
  logic [apsd_pkg::SUM_W-1:0] history_sum;
  logic [15:0] swing_history [apsd_pkg::HISTORY_DEPTH];

  logic active;
  logic rising;
  logic band_ok;
  logic peak;
  logic [31:0] elapsed;
  logic gap_ok;
  logic [16:0] swing;
  logic swing_ok;
  logic step;
  logic update;
  logic hist_full;
  logic [15:0] step_threshold_next;
  logic [apsd_pkg::SUM_W-1:0] history_sum_next;

  assign active = cmt.is_tick == 1'b0 && prev_magnitude != 16'd0;
  assign rising = cmt.mag >= prev_magnitude;
  assign band_ok = prev_magnitude >= cfg.peak_low && prev_magnitude < cfg.peak_high;
  assign peak = !rising && rising_now && rise_run >= cfg.min_rise_count && band_ok;
  assign elapsed = tick_count - last_peak_time;
  assign gap_ok = elapsed >= {24'd0, cfg.min_peak_gap};
  assign swing = {1'b0, prev_magnitude} - {1'b0, valley_value};
  assign swing_ok = active && peak && gap_ok && !swing[16];
  assign step = swing_ok && swing[15:0] >= step_threshold;
  assign update = swing_ok && swing[15:0] >= cfg.min_update_swing;
  assign hist_full = history_fill == apsd_pkg::FILL_W'(apsd_pkg::HISTORY_DEPTH);

  always_comb begin
    step_threshold_next = step_threshold;
    history_sum_next = history_sum + apsd_pkg::SUM_W'(swing[15:0]);
    if (update && hist_full) begin
      step_threshold_next = apsd_pkg::grade(history_sum);
      history_sum_next = history_sum - apsd_pkg::SUM_W'(swing_history[0])
                         + apsd_pkg::SUM_W'(swing[15:0]);
    end
  end

  assign res.step_found = step;
  assign res.magnitude = cmt.mag;
  assign res.threshold_now = step_threshold_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= 32'd0;
      prev_magnitude <= 16'd0;
      rising_now <= 1'b0;
      rise_run <= 4'd0;
      valley_value <= 16'd0;
      last_peak_time <= 32'd0;
      step_threshold <= apsd_pkg::THR_20;
      history_fill <= '0;
      history_sum <= '0;
    end else if (cmt.commit) begin
      if (cmt.is_tick) begin
        tick_count <= tick_count + 32'd1;
      end else begin
        prev_magnitude <= cmt.mag;
        if (active) begin
          rising_now <= rising;
          if (rising) begin
            if (rise_run != 4'd15) begin
              rise_run <= rise_run + 4'd1;
            end
          end else begin
            rise_run <= 4'd0;
          end
          if (!peak && !rising_now && rising) begin
            valley_value <= prev_magnitude;
          end
          if (step || update) begin
            last_peak_time <= tick_count;
          end
          if (update) begin
            step_threshold <= step_threshold_next;
            history_sum <= history_sum_next;
            if (!hist_full) begin
              history_fill <= history_fill + apsd_pkg::FILL_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmt.commit && active && update) begin
      for (int i = 0; i < apsd_pkg::HISTORY_DEPTH - 1; i++) begin
        swing_history[i] <= swing_history[i + 1];
      end
      swing_history[apsd_pkg::HISTORY_DEPTH - 1] <= swing[15:0];
    end
  end

endmodule

`default_nettype wire

// File: hdl/accel_peak_step_detector_top.sv
// Step detector for a three-axis accelerometer stream.
// The sample channel carries either a 10 ms tick or a raw sample; each
// transfer yields exactly one transfer on the result channel, in order.
// A result holds the step pulse, the magnitude of the sample (zero for a
// tick) and the dynamic threshold in force after that item.
// A sample passes from its transfer to a valid result through the shared
// squaring multiplier, the two-bit-per-cycle square root and the decision
// step. Only one item is in flight: the next is taken once the result is
// committed and control is idle again; a tick goes to the decision step.
// Configuration writes are taken in any cycle and should be made only while
// no item is in flight.
// The result register frees the input side: a new item is taken while a
// finished result waits. If the receiver stalls, the next item completes
// its computation and then waits, state unchanged, until the register frees.
// Synchronous reset restores the register defaults, clears the tick counter
// and tracking state and sets the threshold to its initial level.
`default_nettype none

module accel_peak_step_detector_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sample_valid,
  output logic                     sample_ready,
  input  wire apsd_pkg::sample_t   sample,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output apsd_pkg::result_t        result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAG = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic is_tick;
  apsd_pkg::cfg_t cfg;
  apsd_pkg::commit_t cmt;
  apsd_pkg::result_t res;
  logic sq_start;
  logic sq_done;
  logic [31:0] sq_sum;
  logic rt_done;
  logic [15:0] root;
  logic slot_free;
  logic take;

  assign sample_ready = state == ST_IDLE;
  assign take = sample_valid && sample_ready;
  assign sq_start = take && sample.req_type == apsd_pkg::REQ_SAMPLE;
  assign slot_free = !result_valid || result_ready;
  assign cfg_ready = 1'b1;

  assign cmt.commit = state == ST_DONE && slot_free;
  assign cmt.is_tick = is_tick;
  assign cmt.mag = is_tick ? 16'd0 : root;

  apsd_sqsum u_sqsum (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (sample.accel_x),
    .y     (sample.accel_y),
    .z     (sample.accel_z),
    .sum   (sq_sum),
    .done  (sq_done)
  );

  apsd_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_done && state == ST_MAG),
    .radicand (sq_sum),
    .root     (root),
    .done     (rt_done)
  );

  apsd_track u_track (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmt (cmt),
    .res (res)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          state_next = (sample.req_type == apsd_pkg::REQ_TICK) ? ST_DONE : ST_MAG;
        end
      end
      ST_MAG: begin
        if (sq_done) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (rt_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      result_valid <= 1'b0;
      cfg.min_peak_gap <= apsd_pkg::RST_MIN_PEAK_GAP;
      cfg.min_update_swing <= apsd_pkg::RST_MIN_UPDATE_SWING;
      cfg.peak_low <= apsd_pkg::RST_PEAK_LOW;
      cfg.peak_high <= apsd_pkg::RST_PEAK_HIGH;
      cfg.min_rise_count <= apsd_pkg::RST_MIN_RISE_COUNT;
    end else begin
      state <= state_next;
      if (cmt.commit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          apsd_pkg::CFG_MIN_PEAK_GAP: cfg.min_peak_gap <= cfg_data[7:0];
          apsd_pkg::CFG_MIN_UPDATE_SWING: cfg.min_update_swing <= cfg_data;
          apsd_pkg::CFG_PEAK_LOW: cfg.peak_low <= cfg_data;
          apsd_pkg::CFG_PEAK_HIGH: cfg.peak_high <= cfg_data;
          apsd_pkg::CFG_MIN_RISE_COUNT: cfg.min_rise_count <= cfg_data[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      is_tick <= sample.req_type == apsd_pkg::REQ_TICK;
    end
    if (cmt.commit) begin
      result <= res;
    end
  end

  a_sq_done_in_mag: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == ST_MAG)
    else $error("square sum finished outside its state");

  a_rt_done_in_root: assert property (@(posedge clk) disable iff (rst)
    rt_done |-> state == ST_ROOT)
    else $error("square root finished outside its state");

  a_tick_direct: assert property (@(posedge clk) disable iff (rst)
    (take && sample.req_type == apsd_pkg::REQ_TICK) |=> state == ST_DONE && is_tick)
    else $error("tick transfer did not go straight to completion");

  a_commit_frees: assert property (@(posedge clk) disable iff (rst)
    cmt.commit |=> result_valid && state == ST_IDLE)
    else $error("committed item did not reach the result register");

endmodule

`default_nettype wire
